// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the entity decoder modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked only outside reset.
`define XEU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define XEU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define XEU_ASSERT(label, prop, msg)
`define XEU_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// ===== rtl/xeu_pkg.sv =====
// ----------------------------------------------------------------------------
// xeu_pkg
// Shared constants, entity tables and the command type for the decoder.
// ----------------------------------------------------------------------------
package xeu_pkg;

  localparam logic [7:0] AMP_CHAR  = 8'h26;
  localparam logic [7:0] SEMI_CHAR = 8'h3B;

  localparam int NAME_MAX  = 4;
  localparam int ENT_COUNT = 5;
  localparam int MAX_OUT   = NAME_MAX + 2;
  localparam int LEN_W     = $clog2(MAX_OUT + 1);
  localparam int IDX_W     = $clog2(MAX_OUT);
  localparam int HELD_W    = $clog2(NAME_MAX + 2);
  localparam int QDEPTH    = 2;

  localparam logic [HELD_W-1:0] HELD_MAX = HELD_W'(NAME_MAX + 1);

  // One accepted item turns into this: the bytes it releases, in order.
  typedef struct packed {
    logic [MAX_OUT-1:0][7:0] bytes;
    logic [LEN_W-1:0]        len;
    logic                    last;
  } cmd_t;

  // Entity names: lt, gt, amp, quot, apos.
  function automatic logic [7:0] ent_name(input int e, input int j);
    logic [31:0] name;
    case (e)
      0:       name = {"l", "t", 8'h00, 8'h00};
      1:       name = {"g", "t", 8'h00, 8'h00};
      2:       name = {"a", "m", "p", 8'h00};
      3:       name = {"q", "u", "o", "t"};
      4:       name = {"a", "p", "o", "s"};
      default: name = '0;
    endcase
    return name[8*(3-j) +: 8];
  endfunction

  function automatic logic [HELD_W-1:0] ent_len(input int e);
    case (e)
      0, 1:    return HELD_W'(2);
      2:       return HELD_W'(3);
      default: return HELD_W'(4);
    endcase
  endfunction

  function automatic logic [7:0] ent_char(input int e);
    case (e)
      0:       return "<";
      1:       return ">";
      2:       return "&";
      3:       return 8'h22;
      default: return 8'h27;
    endcase
  endfunction

endpackage

// ===== rtl/xeu_in_if.sv =====
// ----------------------------------------------------------------------------
// xeu_in_if
// Input channel: escaped text bytes with an end-of-string flag.
// ----------------------------------------------------------------------------
interface xeu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_text;

  modport source (output valid, output char_in, output end_of_text, input ready);
  modport sink   (input valid, input char_in, input end_of_text, output ready);
endinterface

// ===== rtl/xeu_out_if.sv =====
// ----------------------------------------------------------------------------
// xeu_out_if
// Output channel: unescaped text bytes with a last-byte flag.
// ----------------------------------------------------------------------------
interface xeu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       last_out;

  modport source (output valid, output char_out, output last_out, input ready);
  modport sink   (input valid, input char_out, input last_out, output ready);
endinterface

// ===== rtl/xeu_front.sv =====
// ----------------------------------------------------------------------------
// xeu_front
// Accepts bytes, tracks the pending entity and builds the byte list for each item.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xeu_front (
  input  logic                clk,
  input  logic                rst,
  xeu_in_if.sink              in_ch,
  output logic                push_valid,
  output xeu_pkg::cmd_t       push_cmd,
  input  logic                push_ready
);
  import xeu_pkg::*;

  logic [HELD_W-1:0] held_count;
  logic [HELD_W-1:0] held_count_next;
  logic [7:0]        held_name [NAME_MAX];

  logic [HELD_W-1:0] k;
  logic              accept;
  logic              is_amp;
  logic              is_semi;
  logic              grows;
  logic              matched;
  logic [7:0]        match_char;
  logic              ok;
  logic [7:0]        probe;
  logic              flush;
  logic              extra_v;
  logic [7:0]        extra;
  logic              name_wr;
  logic [LEN_W-1:0]  len;

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = push_ready;
  assign is_amp      = (in_ch.char_in == AMP_CHAR);
  assign is_semi     = (in_ch.char_in == SEMI_CHAR);

  // Number of name bytes held after the ampersand.
  always_comb begin
    if (held_count == '0) begin
      k = '0;
    end else if (held_count > HELD_MAX) begin
      k = HELD_W'(NAME_MAX);
    end else begin
      k = held_count - HELD_W'(1);
    end
  end

  // Prefix and full-name checks against all entities in parallel.
  always_comb begin
    grows      = 1'b0;
    matched    = 1'b0;
    match_char = '0;
    for (int e = 0; e < ENT_COUNT; e++) begin
      ok = (k + HELD_W'(1)) <= ent_len(e);
      for (int j = 0; j < NAME_MAX; j++) begin
        probe = (HELD_W'(j) < k) ? held_name[j] : in_ch.char_in;
        if (HELD_W'(j) <= k && probe != ent_name(e, j)) begin
          ok = 1'b0;
        end
      end
      if (ok) begin
        grows = 1'b1;
      end
      ok = (k == ent_len(e));
      for (int j = 0; j < NAME_MAX; j++) begin
        if (HELD_W'(j) < k && held_name[j] != ent_name(e, j)) begin
          ok = 1'b0;
        end
      end
      if (ok && !matched) begin
        matched    = 1'b1;
        match_char = ent_char(e);
      end
    end
  end

  // Classify the item: flush the held bytes, append one extra byte, or hold.
  always_comb begin
    flush           = 1'b0;
    extra_v         = 1'b0;
    extra           = in_ch.char_in;
    name_wr         = 1'b0;
    held_count_next = '0;
    if (held_count == '0) begin
      if (is_amp) begin
        extra_v         = in_ch.end_of_text;
        held_count_next = in_ch.end_of_text ? '0 : HELD_W'(1);
      end else begin
        extra_v = 1'b1;
      end
    end else if (is_amp) begin
      flush           = 1'b1;
      extra_v         = in_ch.end_of_text;
      held_count_next = in_ch.end_of_text ? '0 : HELD_W'(1);
    end else if (is_semi) begin
      if (matched) begin
        extra_v = 1'b1;
        extra   = match_char;
      end else begin
        flush   = 1'b1;
        extra_v = 1'b1;
      end
    end else if (k < HELD_W'(NAME_MAX) && grows && !in_ch.end_of_text) begin
      name_wr         = 1'b1;
      held_count_next = held_count + HELD_W'(1);
    end else begin
      // A broken prefix, or a good one cut short by the end of the string.
      flush   = 1'b1;
      extra_v = 1'b1;
    end
  end

  assign len = (flush ? LEN_W'(k + HELD_W'(1)) : '0) + LEN_W'(extra_v);

  always_comb begin
    push_cmd.bytes[0] = flush ? AMP_CHAR : extra;
    for (int i = 0; i < NAME_MAX; i++) begin
      push_cmd.bytes[i + 1] = (flush && HELD_W'(i) < k) ? held_name[i] : extra;
    end
    push_cmd.bytes[MAX_OUT-1] = extra;
    push_cmd.len  = len;
    push_cmd.last = in_ch.end_of_text;
  end

  assign push_valid = accept && (len != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
    end else if (accept) begin
      held_count <= held_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && name_wr) begin
      held_name[k[$clog2(NAME_MAX)-1:0]] <= in_ch.char_in;
    end
  end

  `XEU_ASSERT(a_held_range, held_count <= HELD_MAX, "held count out of range")
  `XEU_ASSERT(a_push_len, push_valid |-> push_cmd.len <= LEN_W'(MAX_OUT), "command too long")
  `XEU_ASSERT(a_end_clears, accept && in_ch.end_of_text |=> held_count == '0, "bytes kept")
  `XEU_ASSERT(a_end_emits, accept && in_ch.end_of_text |-> push_valid, "no output at end")

endmodule

// ===== rtl/xeu_queue.sv =====
// ----------------------------------------------------------------------------
// xeu_queue
// Short command queue between the classifier and the serializer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xeu_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  input  xeu_pkg::cmd_t push_cmd,
  output logic          push_ready,
  output logic          pop_valid,
  output xeu_pkg::cmd_t pop_cmd,
  input  logic          pop_ready
);
  import xeu_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  cmd_t             entry [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entry[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  `XEU_ASSERT(a_no_overflow, count == CNT_W'(QDEPTH) |-> !push_valid, "push into full queue")
  `XEU_ASSERT(a_nonempty_cmd, pop_valid |-> pop_cmd.len != '0, "empty command queued")
  `XEU_ASSERT(a_count_step, do_push && !do_pop |=> count == $past(count) + CNT_W'(1), "count lost a push")

endmodule

// ===== rtl/xeu_back.sv =====
// ----------------------------------------------------------------------------
// xeu_back
// Serializes each command into bytes, one per cycle unless the output stalls.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xeu_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          pop_valid,
  input  xeu_pkg::cmd_t pop_cmd,
  output logic          pop_ready,
  xeu_out_if.source     out_ch
);
  import xeu_pkg::*;

  logic [IDX_W-1:0] idx;
  logic             at_end;
  logic             fire;

  assign at_end          = (LEN_W'(idx) == pop_cmd.len - LEN_W'(1));
  assign out_ch.valid    = pop_valid;
  assign out_ch.char_out = pop_cmd.bytes[idx];
  assign out_ch.last_out = pop_cmd.last && at_end;
  assign fire            = out_ch.valid && out_ch.ready;
  assign pop_ready       = fire && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (fire) begin
      idx <= at_end ? '0 : idx + IDX_W'(1);
    end
  end

  `XEU_ASSERT(a_idx_in_cmd, pop_valid |-> LEN_W'(idx) < pop_cmd.len, "byte index past command")
  `XEU_ASSERT(a_last_restarts, fire && out_ch.last_out |=> idx == '0, "index not reset after last byte")
  `XEU_ASSERT_ALWAYS(a_idx_reset, rst |=> idx == '0, "index not cleared by reset")

endmodule

// ===== rtl/xml_entity_unescaper.sv =====
// Ordering: each accepted item is registered in the command queue before its first byte is offered.
// Throughput: one item per cycle while items release at most one byte each and the
// output takes them; an item releasing n bytes (n up to six) holds the serializer until
// all are sent; a two-entry command queue lets input go on meanwhile until it fills.
// Reset: synchronous, clears the pending-ampersand state, the queue and the serializer;
// held name bytes are not cleared.
// ----------------------------------------------------------------------------
// xml_entity_unescaper
// Streaming decoder for the five predefined XML entities.
// ----------------------------------------------------------------------------
module xml_entity_unescaper (
  input  logic       clk,
  input  logic       rst,
  xeu_in_if.sink     in_ch,
  xeu_out_if.source  out_ch
);
  import xeu_pkg::*;

  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  xeu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  xeu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop_ready  (pop_ready)
  );

  xeu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_cmd   (pop_cmd),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for xml_entity_unescaper. Escaped text is sent through the input
// channel: first a few directed strings, then random text made mostly of
// well-formed entities. Both channels idle at random. A local decoder
// predicts the unescaped bytes, and each output item is checked in order.
// ----------------------------------------------------------------------------
module tb_top;
  import xeu_pkg::*;

  localparam int STALL_LIMIT  = 1000;
  localparam int RANDOM_ITEMS = 330;
  localparam int QUIET_ITEMS  = 60;
  localparam int DRAIN_CYCLES = 10;
  localparam int PRINT_LIMIT  = 100;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_byte_t;

  logic clk = 1'b0;
  logic rst;

  xeu_in_if  in_ch ();
  xeu_out_if out_ch ();

  xml_entity_unescaper i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decoder state: amp_held is 0 with no ampersand pending, else 1 plus the
  // number of name bytes held in name_held.
  logic [2:0] amp_held;
  logic [7:0] name_held [4];
  logic [7:0] released [$];
  logic [7:0] burst [$];
  text_byte_t expected_text [$];

  int mismatch_count = 0;
  int items_sent = 0;
  bit src_idle_on = 1'b0;
  bit sink_idle_on = 1'b0;

  function automatic string entity_word(input int e);
    case (e)
      0:       return "lt";
      1:       return "gt";
      2:       return "amp";
      3:       return "quot";
      default: return "apos";
    endcase
  endfunction

  function automatic logic [7:0] entity_glyph(input int e);
    case (e)
      0:       return 8'h3C;
      1:       return 8'h3E;
      2:       return 8'h26;
      3:       return 8'h22;
      default: return 8'h27;
    endcase
  endfunction

  function automatic int held_len();
    if (amp_held == 3'd0) return 0;
    return (amp_held > 3'd5) ? NAME_MAX : int'(amp_held) - 1;
  endfunction

  // True if the held name followed by ch is still the start of some entity.
  function automatic bit name_grows(input logic [7:0] ch);
    int k;
    string word;
    bit same;
    k = held_len();
    for (int e = 0; e < ENT_COUNT; e++) begin
      word = entity_word(e);
      if (k + 1 <= word.len()) begin
        same = (word[k] == ch);
        for (int i = 0; i < k; i++)
          if (word[i] != name_held[i]) same = 1'b0;
        if (same) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic int matched_entity();
    int k;
    string word;
    bit same;
    k = held_len();
    for (int e = 0; e < ENT_COUNT; e++) begin
      word = entity_word(e);
      same = (k == word.len());
      for (int i = 0; i < k && same; i++)
        if (word[i] != name_held[i]) same = 1'b0;
      if (same) return e;
    end
    return -1;
  endfunction

  function automatic void release_held();
    int k;
    k = held_len();
    if (amp_held != 3'd0) begin
      released.push_back(AMP_CHAR);
      for (int i = 0; i < k; i++) released.push_back(name_held[i]);
      amp_held = 3'd0;
    end
  endfunction

  // Advances the decoder by one input item and queues the bytes it releases.
  function automatic void unescape_char(input logic [7:0] ch, input logic eot);
    int hit;
    text_byte_t nb;
    released.delete();
    if (amp_held == 3'd0) begin
      if (ch == AMP_CHAR) amp_held = 3'd1;
      else released.push_back(ch);
    end else if (ch == AMP_CHAR) begin
      release_held();
      amp_held = 3'd1;
    end else if (ch == SEMI_CHAR) begin
      hit = matched_entity();
      if (hit >= 0) begin
        released.push_back(entity_glyph(hit));
        amp_held = 3'd0;
      end else begin
        release_held();
        released.push_back(ch);
      end
    end else if (held_len() < NAME_MAX && name_grows(ch)) begin
      name_held[held_len()] = ch;
      amp_held = amp_held + 3'd1;
    end else begin
      release_held();
      released.push_back(ch);
    end
    if (eot) release_held();
    foreach (released[i]) begin
      nb.ch = released[i];
      nb.last = eot && (i == released.size() - 1);
      expected_text.push_back(nb);
    end
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  task automatic send_char(input logic [7:0] ch, input logic eot);
    if (src_idle_on && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.char_in <= ch;
    in_ch.end_of_text <= eot;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    unescape_char(ch, eot);
    items_sent++;
  endtask

  task automatic send_text(input string s, input logic eot);
    for (int i = 0; i < s.len(); i++) send_char(s[i], eot && (i == s.len() - 1));
  endtask

  task automatic send_burst(input logic eot);
    foreach (burst[i]) send_char(burst[i], eot && (i == burst.size() - 1));
    burst.delete();
  endtask

  task automatic test_plain_bytes();
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
  endtask

  // Includes an ampersand that arrives while another one is pending.
  task automatic test_entities();
    send_text("&lt;", 1'b0);
    send_text("&&gt;", 1'b0);
    send_text("&amp;", 1'b1);
  endtask

  // Empty name, unknown name before a semicolon, a full-length name broken
  // by one more byte, and a string that ends in the middle of a name.
  task automatic test_broken_names();
    send_text("&;", 1'b0);
    send_text("&ap;", 1'b0);
    send_text("&quotx", 1'b0);
    send_text("&a", 1'b1);
  endtask

  task automatic test_random_text();
    int first;
    int pick;
    int n;
    string word;
    logic eot;
    first = items_sent;
    while (items_sent < first + RANDOM_ITEMS) begin
      if (items_sent >= first + RANDOM_ITEMS - QUIET_ITEMS) begin
        src_idle_on = 1'b0;
        sink_idle_on = 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        src_idle_on = $urandom_range(0, 1);
        sink_idle_on = $urandom_range(0, 1);
      end
      eot = ($urandom_range(0, 5) == 0);
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        send_text({"&", entity_word($urandom_range(0, ENT_COUNT - 1)), ";"}, eot);
      end else if (pick < 7) begin
        // A name prefix, perhaps whole, then perhaps a byte that may or may not break it.
        word = entity_word($urandom_range(0, ENT_COUNT - 1));
        n = $urandom_range(0, word.len());
        burst.push_back(AMP_CHAR);
        for (int i = 0; i < n; i++) burst.push_back(word[i]);
        case ($urandom_range(0, 3))
          0:       burst.push_back(SEMI_CHAR);
          1:       burst.push_back(AMP_CHAR);
          2:       burst.push_back(8'($urandom_range(0, 255)));
          default: ;
        endcase
        send_burst(eot);
      end else begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) burst.push_back(8'($urandom_range(0, 255)));
        send_burst(eot);
      end
    end
  endtask

  // Output side: checks accepted items and stalls in random bursts.
  initial begin
    int stall;
    text_byte_t want;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        if (expected_text.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %h last %b",
                                    out_ch.char_out, out_ch.last_out));
        end else begin
          want = expected_text.pop_front();
          if (out_ch.char_out !== want.ch)
            report_mismatch($sformatf("char_out %h, expected %h", out_ch.char_out, want.ch));
          if (out_ch.last_out !== want.last)
            report_mismatch($sformatf("last_out %b, expected %b on byte %h",
                                      out_ch.last_out, want.last, want.ch));
        end
      end
      if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 16) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when nothing moves on either channel for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.char_in <= 8'h00;
    in_ch.end_of_text <= 1'b0;
    amp_held = 3'd0;
    foreach (name_held[i]) name_held[i] = 8'h00;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    test_plain_bytes();
    test_entities();
    test_broken_names();
    test_random_text();
    in_ch.valid <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
